/* rtl/core/ang_pkg.sv */
`timescale 1ns / 1ps

package ang_pkg;

  localparam int WINDOW       = 256;
  localparam int POS_W        = $clog2(WINDOW);
  localparam int WIN_W        = $clog2(WINDOW + 1);
  localparam int SAMPLE_W     = 16;
  localparam int SQ_W         = 31;
  localparam int SUM_W        = SQ_W + POS_W;
  localparam int THR_W        = 31;
  localparam int THR_SCALED_W = THR_W + WIN_W;
  localparam int COEF_W       = 16;
  localparam int HOLD_W       = 20;
  localparam int CNT_W        = HOLD_W + 1;
  localparam int GAIN_W       = COEF_W + 1;
  localparam int MUL_W        = COEF_W + GAIN_W;
  localparam int OPROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_IDX_W    = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_SQ = 2'd0,
    REG_CLOSE_COEFF  = 2'd1,
    REG_OPEN_COEFF   = 2'd2,
    REG_HOLD_SAMPLES = 2'd3
  } cfg_reg_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_READ = 8'b0000_0010,
    ST_SUM  = 8'b0000_0100,
    ST_GATE = 8'b0000_1000,
    ST_COEF = 8'b0001_0000,
    ST_UPD  = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [SQ_W-1:0]  data;
  } ring_wr_t;

endpackage

/* rtl/core/audio_noise_gate_with_hold.sv */
`timescale 1ns / 1ps

// Noise gate with a boxcar mean-square detector over the last WINDOW samples,
// hold counters and a one-pole gain smoother. The input is stalled from
// acceptance until the item leaves the emit step, which waits while an older
// result is held under out_stall; the result is registered on the way out, so
// the next item may be accepted while the last result waits. Each item passes
// the read-modify-write of the square ring, the detector compare, the
// coefficient multiply, the gain update and the output multiply, one step each.
// Ring entries read as zero after reset until written, so no clearing pass is
// needed. Config registers may be written only while the block is idle.
module audio_noise_gate_with_hold (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_sample_out,
  input  logic                           cfg_we,
  input  logic [ang_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ang_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ang_pkg::*;

  state_t state_r, state_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [COEF_W-1:0] close_coeff_r;
  logic [COEF_W-1:0] open_coeff_r;
  logic [HOLD_W-1:0] hold_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [SQ_W-1:0]            sq_r;
  logic [POS_W-1:0]           pos_r;
  logic [SUM_W-1:0]           sum_r;
  logic [CNT_W-1:0]           cls_cnt_r;
  logic [CNT_W-1:0]           opn_cnt_r;
  logic [GAIN_W-1:0]          gain_r;
  logic                       target_r;
  logic                       closing_r;
  logic                       smooth_r;
  logic [COEF_W-1:0]          coef_r;
  logic [MUL_W-1:0]           mul_r;
  logic signed [OPROD_W-1:0]  oprod_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic                       accept;
  logic                       emit;
  logic [SQ_W-1:0]            old_sq;
  ring_wr_t                   ring_wr;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [THR_SCALED_W-1:0]    thr_scaled;
  logic                       target;
  logic                       closing;
  logic [GAIN_W-1:0]          inv_coef;
  logic [MUL_W:0]             acc;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign emit     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  assign ring_wr.en   = (state_r == ST_SUM);
  assign ring_wr.addr = pos_r;
  assign ring_wr.data = sq_r;

  ang_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (pos_r),
    .wr      (ring_wr),
    .rd_data (old_sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r         <= '0;
      close_coeff_r <= '0;
      open_coeff_r  <= '0;
      hold_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD_SQ: thr_r         <= cfg_data[THR_W-1:0];
        REG_CLOSE_COEFF:  close_coeff_r <= cfg_data[COEF_W-1:0];
        REG_OPEN_COEFF:   open_coeff_r  <= cfg_data[COEF_W-1:0];
        REG_HOLD_SAMPLES: hold_r        <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_GATE;
      ST_GATE: state_nxt = ST_COEF;
      ST_COEF: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EMIT;
      ST_EMIT: if (emit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign sq_full    = sample_r * sample_r;
  assign thr_scaled = THR_SCALED_W'(thr_r) * THR_SCALED_W'(WINDOW);
  assign target     = !(THR_SCALED_W'(sum_r) < thr_scaled);
  // target 0 always closes; full target counts as closing once the gain is full
  assign closing    = !target || (gain_r == GAIN_ONE);
  assign inv_coef   = GAIN_ONE - GAIN_W'(coef_r);
  assign acc        = (MUL_W + 1)'(mul_r)
                    + (target_r ? (MUL_W + 1)'({inv_coef, {COEF_W{1'b0}}}) : '0);

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample_in;
    end
    if (state_r == ST_READ) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
    if (state_r == ST_GATE) begin
      target_r  <= target;
      closing_r <= closing;
    end
    if (state_r == ST_COEF) begin
      mul_r <= MUL_W'(coef_r) * MUL_W'(gain_r);
    end
    if (state_r == ST_MUL) begin
      oprod_r <= OPROD_W'(sample_r) * $signed(OPROD_W'(gain_r));
    end
    if (emit) begin
      out_sample_r <= oprod_r[COEF_W +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      sum_r       <= '0;
      cls_cnt_r   <= '0;
      opn_cnt_r   <= '0;
      gain_r      <= '0;
      smooth_r    <= 1'b0;
      coef_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SUM) begin
        sum_r <= sum_r - SUM_W'(old_sq) + SUM_W'(sq_r);
        pos_r <= (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      end
      if (state_r == ST_GATE) begin
        coef_r <= closing ? close_coeff_r : open_coeff_r;
        if (closing) begin
          smooth_r  <= (cls_cnt_r > CNT_W'(hold_r));
          if (!(cls_cnt_r > CNT_W'(hold_r))) cls_cnt_r <= cls_cnt_r + 1'b1;
          opn_cnt_r <= '0;
        end else begin
          smooth_r  <= (opn_cnt_r > CNT_W'(hold_r));
          if (!(opn_cnt_r > CNT_W'(hold_r))) opn_cnt_r <= opn_cnt_r + 1'b1;
          cls_cnt_r <= '0;
        end
      end
      if ((state_r == ST_UPD) && smooth_r) begin
        gain_r <= acc[COEF_W +: GAIN_W];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= GAIN_ONE)
    else $error("gain above unity");

  a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
    !((cls_cnt_r != '0) && (opn_cnt_r != '0)))
    else $error("both hold counters running");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result loaded outside emit step");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SUM) |=> $stable(pos_r) && $stable(sum_r))
    else $error("ring position or sum moved outside the update step");

endmodule

/* rtl/core/ang_ring.sv */
`timescale 1ns / 1ps

module ang_ring (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [ang_pkg::POS_W-1:0] rd_addr,
  input  ang_pkg::ring_wr_t        wr,
  output logic [ang_pkg::SQ_W-1:0] rd_data
);
  import ang_pkg::*;

  logic [SQ_W-1:0]   mem [WINDOW];
  logic [WINDOW-1:0] vld_r;
  logic [SQ_W-1:0]   rd_q_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // per-entry valid bits stand in for clearing the ring after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
